/* hdl/wsfd_pkg.sv */
// Shared types and constants for the websocket frame deframer.
// No dependencies; imported by every module of the block.
package wsfd_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam int unsigned LenWidth  = 64;
  localparam int unsigned HdrWidth  = 4;
  localparam int unsigned KeyWidth  = 32;
  localparam int unsigned OutDataWidth = 88;

  localparam logic [6:0] LenCode16 = 7'd126;
  localparam logic [6:0] LenCode64 = 7'd127;

  localparam logic [HdrWidth-1:0] HdrLenShort = 4'd2;
  localparam logic [HdrWidth-1:0] HdrLen16    = 4'd4;
  localparam logic [HdrWidth-1:0] HdrLen64    = 4'd10;
  localparam logic [HdrWidth-1:0] HdrKeyBytes = 4'd4;

  localparam logic [2:0] ExtBytes16 = 3'd2;
  localparam logic [2:0] ExtBytes64 = 3'd0;  // wraps: eight bytes
  localparam logic [2:0] KeyBytes   = 3'd4;

  typedef enum logic {
    KIND_HEADER  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } item_kind_e;

  // classified word handed from the parser to the output stage
  typedef struct packed {
    item_kind_e           kind;
    logic                 fin;
    logic [3:0]           opcode;
    logic                 masked;
    logic [LenWidth-1:0]  len;
    logic [HdrWidth-1:0]  hdr_len;
    logic [7:0]           data;
    logic [7:0]           key;
    logic                 last;
  } cmd_t;

endpackage

/* hdl/websocket_frame_deframer_core.sv */
// Top level of the websocket frame deframer: parser, word queue, output stage.
// Depends on wsfd_pkg, wsfd_front, wsfd_queue, wsfd_back.
//
// Takes one received byte per cycle and decodes RFC 6455 frames. No word comes
// out while header bytes arrive; one header word follows the last header byte
// (FIN, opcode, MASK, length, header length), then one unmasked payload word
// per payload byte. tlast marks the last word of a frame, which is the header
// word for an empty frame. Throughput is one byte per cycle; an accepted byte's
// word is registered first in the queue and then in the output register. The
// input stalls only when the queue of QueueDepth words is full.
module websocket_frame_deframer_core #(
  parameter int unsigned QueueDepth = wsfd_pkg::QueueDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [7:0]                        s_axis_tdata_i,   // [7:0] rx_byte
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [0] fin_flag, [4:1] frame_opcode, [5] mask_present, [69:6] payload_length,
  // [73:70] header_length, [81:74] payload_byte, [87:82] zero
  output logic [wsfd_pkg::OutDataWidth-1:0] m_axis_tdata_o,
  output logic                              m_axis_tuser_o,   // [0] item_kind
  output logic                              m_axis_tlast_o    // frame_end
);
  import wsfd_pkg::*;

  logic room, push, pop, q_valid;
  cmd_t push_cmd, q_cmd;

  wsfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_byte_i  (s_axis_tdata_i),
    .room_i     (room),
    .in_ready_o (s_axis_tready_o),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  wsfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .room_o  (room),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (q_cmd)
  );

  wsfd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (q_valid),
    .cmd_i     (q_cmd),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o),
    .m_kind_o  (m_axis_tuser_o),
    .m_last_o  (m_axis_tlast_o)
  );

endmodule

/* hdl/wsfd_front.sv */
// Frame header parser: accepts stream bytes and emits classified words.
// Depends on wsfd_pkg.
module wsfd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    in_byte_i,
  input  logic          room_i,
  output logic          in_ready_o,
  output logic          push_o,
  output wsfd_pkg::cmd_t cmd_o
);
  import wsfd_pkg::*;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [2:0]            ext_q, ext_d;
  logic                  fin_q, fin_d;
  logic [3:0]            opc_q, opc_d;
  logic                  msk_q, msk_d;
  logic [LenWidth-1:0]   len_q, len_d;
  logic [KeyWidth-1:0]   key_q, key_d;
  logic [LenWidth-1:0]   rem_q, rem_d;
  logic [1:0]            midx_q, midx_d;
  logic [HdrWidth-1:0]   hdr_q, hdr_d;

  logic                  acc;
  logic                  len_done;
  logic                  hdr_done;
  logic [7:0]            key_byte;

  assign in_ready_o = room_i;
  assign acc        = in_valid_i && room_i;
  assign key_byte   = msk_q ? key_q[{~midx_q, 3'b000} +: 8] : 8'h00;

  always_comb begin
    phase_d  = phase_q;
    ext_d    = ext_q;
    fin_d    = fin_q;
    opc_d    = opc_q;
    msk_d    = msk_q;
    len_d    = len_q;
    key_d    = key_q;
    rem_d    = rem_q;
    midx_d   = midx_q;
    hdr_d    = hdr_q;
    len_done = 1'b0;
    hdr_done = 1'b0;
    push_o   = 1'b0;
    cmd_o    = '0;
    if (acc) begin
      unique case (phase_q)
        PH_SECOND: begin
          msk_d = in_byte_i[7];
          len_d = '0;
          if (in_byte_i[6:0] == LenCode16) begin
            ext_d   = ExtBytes16;
            hdr_d   = HdrLen16;
            phase_d = PH_EXTLEN;
          end else if (in_byte_i[6:0] == LenCode64) begin
            ext_d   = ExtBytes64;
            hdr_d   = HdrLen64;
            phase_d = PH_EXTLEN;
          end else begin
            len_d    = {{(LenWidth-7){1'b0}}, in_byte_i[6:0]};
            hdr_d    = HdrLenShort;
            len_done = 1'b1;
          end
        end
        PH_EXTLEN: begin
          len_d    = {len_q[LenWidth-9:0], in_byte_i};
          ext_d    = ext_q - 3'd1;
          len_done = (ext_d == 3'd0);
        end
        PH_KEY: begin
          key_d    = {key_q[KeyWidth-9:0], in_byte_i};
          ext_d    = ext_q - 3'd1;
          hdr_done = (ext_d == 3'd0);
        end
        PH_PAYLOAD: begin
          midx_d       = midx_q + 2'd1;
          rem_d        = rem_q - LenWidth'(1);
          push_o       = 1'b1;
          cmd_o.kind   = KIND_PAYLOAD;
          cmd_o.fin    = fin_q;
          cmd_o.opcode = opc_q;
          cmd_o.masked = msk_q;
          cmd_o.len    = len_q;
          cmd_o.hdr_len = hdr_q;
          cmd_o.data   = in_byte_i;
          cmd_o.key    = key_byte;
          cmd_o.last   = (rem_d == '0);
          if (rem_d == '0) phase_d = PH_FIRST;
        end
        default: begin
          fin_d   = in_byte_i[7];
          opc_d   = in_byte_i[3:0];
          phase_d = PH_SECOND;
        end
      endcase

      if (len_done) begin
        if (msk_d) begin
          hdr_d   = hdr_d + HdrKeyBytes;
          ext_d   = KeyBytes;
          key_d   = '0;
          phase_d = PH_KEY;
        end else begin
          hdr_done = 1'b1;
        end
      end

      if (hdr_done) begin
        rem_d         = len_d;
        midx_d        = 2'd0;
        push_o        = 1'b1;
        cmd_o.kind    = KIND_HEADER;
        cmd_o.fin     = fin_d;
        cmd_o.opcode  = opc_d;
        cmd_o.masked  = msk_d;
        cmd_o.len     = len_d;
        cmd_o.hdr_len = hdr_d;
        cmd_o.last    = (len_d == '0);
        phase_d       = (len_d == '0) ? PH_FIRST : PH_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      ext_q   <= '0;
      fin_q   <= 1'b0;
      opc_q   <= '0;
      msk_q   <= 1'b0;
      len_q   <= '0;
      key_q   <= '0;
      rem_q   <= '0;
      midx_q  <= '0;
      hdr_q   <= '0;
    end else begin
      phase_q <= phase_d;
      ext_q   <= ext_d;
      fin_q   <= fin_d;
      opc_q   <= opc_d;
      msk_q   <= msk_d;
      len_q   <= len_d;
      key_q   <= key_d;
      rem_q   <= rem_d;
      midx_q  <= midx_d;
      hdr_q   <= hdr_d;
    end
  end

  a_key_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_KEY) |-> (ext_q != 3'd0 && ext_q <= KeyBytes))
    else $error("key byte count out of range");

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (rem_q != '0))
    else $error("payload phase with nothing remaining");

  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> acc)
    else $error("word pushed without an accepted byte");

endmodule

/* hdl/wsfd_queue.sv */
// Short FIFO of classified words between parser and output stage.
// Depends on wsfd_pkg.
module wsfd_queue #(
  parameter int unsigned Depth = wsfd_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wsfd_pkg::cmd_t wdata_i,
  output logic           room_o,
  input  logic           pop_i,
  output logic           valid_o,
  output wsfd_pkg::cmd_t rdata_o
);
  import wsfd_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign room_o  = (cnt_q != FullCnt);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && room_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
      if (do_pop)  rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue count overflow");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> room_o)
    else $error("word pushed into full queue");

endmodule

/* hdl/wsfd_back.sv */
// Output stage: unmasks payload bytes and holds the result word for the sink.
// Depends on wsfd_pkg.
module wsfd_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  wsfd_pkg::cmd_t                       cmd_i,
  output logic                                 pop_o,
  output logic                                 m_valid_o,
  input  logic                                 m_ready_i,
  output logic [wsfd_pkg::OutDataWidth-1:0]    m_data_o,
  output logic                                 m_kind_o,
  output logic                                 m_last_o
);
  import wsfd_pkg::*;

  localparam int unsigned PackW = 1 + 4 + 1 + LenWidth + HdrWidth + 8;

  logic                    vld_q;
  logic [OutDataWidth-1:0] data_q;
  logic                    kind_q, last_q;
  logic                    load;

  assign load      = valid_i && (!vld_q || m_ready_i);
  assign pop_o     = load;
  assign m_valid_o = vld_q;
  assign m_data_o  = data_q;
  assign m_kind_o  = kind_q;
  assign m_last_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= 1'b1;
    end else if (m_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= {{(OutDataWidth-PackW){1'b0}}, cmd_i.data ^ cmd_i.key, cmd_i.hdr_len,
                 cmd_i.len, cmd_i.masked, cmd_i.opcode, cmd_i.fin};
      kind_q <= cmd_i.kind;
      last_q <= cmd_i.last;
    end
  end

  a_hdr_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_o && (m_kind_o == KIND_HEADER)) |-> (m_data_o[PackW-1 -: 8] == 8'h00))
    else $error("header word carries a data byte");

endmodule
